@@ sv/ptrt_pkg.sv @@
package ptrt_pkg;

  localparam int unsigned TASK_SLOTS_DEF = 8;
  localparam int unsigned TICK_MS_DEF    = 1;

  localparam int unsigned MS_W     = 16;
  localparam int unsigned TICKS_W  = 16;
  localparam int unsigned COUNT_W  = 24;
  localparam int unsigned PAUSE_W  = 8;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_PAUSE  = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_DUE  = 2'd1;
  localparam logic [1:0] KIND_IDLE = 2'd2;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // Control that the sequencer broadcasts to every slot cell.
  typedef struct packed {
    logic create;
    logic pause;
    logic remove;
    logic tick;
    logic shift;
  } cell_ctl_t;

endpackage

@@ sv/ptrt_ms2tick.sv @@
module ptrt_ms2tick #(
  parameter int unsigned TICK_MS = ptrt_pkg::TICK_MS_DEF
) (
  input  logic [ptrt_pkg::MS_W-1:0]    ms_i,
  output logic [ptrt_pkg::TICKS_W-1:0] ticks_o
);

  // Division by the tick length as a multiply by a rounded-up reciprocal.
  // With a 32-bit fraction the result is exact for every 16-bit input.
  localparam int unsigned FRAC_W = 32;
  localparam longint unsigned RECIP_L = ((64'd1 << FRAC_W) + TICK_MS - 1) / TICK_MS;
  localparam logic [FRAC_W:0] RECIP = (FRAC_W + 1)'(RECIP_L);
  localparam int unsigned PROD_W = FRAC_W + 1 + ptrt_pkg::MS_W;

  logic [PROD_W-1:0] prod;

  assign prod    = PROD_W'(ms_i) * PROD_W'(RECIP);
  assign ticks_o = prod[FRAC_W +: ptrt_pkg::TICKS_W];

endmodule

@@ sv/ptrt_cell.sv @@
module ptrt_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ptrt_pkg::cell_ctl_t             ctl_i,
  input  logic                            sel_i,
  input  logic [ptrt_pkg::TICKS_W-1:0]    period_i,
  input  logic [ptrt_pkg::COUNT_W-1:0]    count_i,
  input  logic                            due_next_i,
  output logic                            due_o
);

  logic                         registered_q, registered_d;
  logic                         due_q, due_d;
  logic [ptrt_pkg::TICKS_W-1:0] period_q, period_d;
  logic [ptrt_pkg::COUNT_W-1:0] count_q, count_d;
  logic [ptrt_pkg::COUNT_W-1:0] reload;

  assign reload = ptrt_pkg::COUNT_W'(period_q);

  always_comb begin
    registered_d = registered_q;
    due_d        = due_q;
    period_d     = period_q;
    count_d      = count_q;
    if (sel_i && ctl_i.create) begin
      registered_d = 1'b1;
      period_d     = period_i;
      count_d      = count_i;
    end
    if (sel_i && ctl_i.pause && registered_q) begin
      count_d = count_i;
    end
    if (sel_i && ctl_i.remove) begin
      registered_d = 1'b0;
    end
    if (ctl_i.tick) begin
      due_d = registered_q && (count_q == '0);
      if (registered_q) begin
        // A due slot reloads and then takes this tick's decrement at once.
        if (count_q == '0) begin
          count_d = (reload == '0) ? '0 : reload - 1'b1;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
    end
    if (ctl_i.shift) begin
      due_d = due_next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      registered_q <= 1'b0;
      due_q        <= 1'b0;
    end else begin
      registered_q <= registered_d;
      due_q        <= due_d;
    end
  end

  always_ff @(posedge clk_i) begin
    period_q <= period_d;
    count_q  <= count_d;
  end

  assign due_o = due_q;

endmodule

@@ sv/periodic_task_release_table_unit.sv @@
// Release table for TASK_SLOTS periodic tasks. A request is taken when start_i
// is high and busy_o is low; every result shows on the result ports for one
// cycle with strobe_o high and cannot be held off, so the receiver must take
// it then. An out-of-range command answers in the cycle after the request,
// delete passes through S_APPLY, pause through S_DIV1 and S_APPLY and create
// through S_DIV1, S_DIV2 and S_APPLY (each millisecond value passes through one
// shared reciprocal multiplier, one per cycle). A tick updates all slots when it
// is taken, then the due flags shift through the chain of slot cells one slot
// per cycle toward slot 0; it ends right after its last due slot is reported.
// busy_o falls in the cycle that carries the final result.
module periodic_task_release_table_unit #(
  parameter int unsigned TASK_SLOTS = ptrt_pkg::TASK_SLOTS_DEF,
  parameter int unsigned TICK_MS    = ptrt_pkg::TICK_MS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  op_i,
  input  logic [5:0]  task_index_i,
  input  logic [15:0] offset_ms_i,
  input  logic [15:0] period_ms_i,
  input  logic [7:0]  pause_count_i,
  output logic        strobe_o,
  output logic [1:0]  kind_o,
  output logic        status_o,
  output logic [2:0]  due_task_o,
  output logic        last_o
);

  localparam int unsigned SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV1  = 3'd1;
  localparam logic [2:0] S_DIV2  = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;

  logic [2:0] state_q, state_d;

  logic [1:0]                    op_q;
  logic [SW-1:0]                 idx_q;
  logic [ptrt_pkg::MS_W-1:0]     offset_q, period_q;
  logic [ptrt_pkg::PAUSE_W-1:0]  pause_q;
  logic [ptrt_pkg::TICKS_W-1:0]  q1_q, q1_d, q2_q, q2_d;
  logic [SW-1:0]                 step_q, step_d;

  logic        strobe_q, strobe_d;
  logic [1:0]  kind_q, kind_d;
  logic        status_q, status_d;
  logic [2:0]  due_task_q, due_task_d;
  logic        last_q, last_d;

  logic                         accept;
  logic                         in_range;
  logic [ptrt_pkg::MS_W-1:0]    div_in;
  logic [ptrt_pkg::TICKS_W-1:0] div_out;
  logic [ptrt_pkg::COUNT_W-1:0] count_wr;
  logic [TASK_SLOTS-1:0]        due_w;
  logic                         any_due, rest_due;
  logic [SW+2:0]                step_wide;
  ptrt_pkg::cell_ctl_t          ctl;

  assign accept   = start_i && (state_q == S_IDLE);
  assign in_range = {1'b0, task_index_i} < 7'(TASK_SLOTS);

  // Create converts the offset first and the period second; pause converts the period.
  assign div_in = ((state_q == S_DIV1) && (op_q == ptrt_pkg::OP_CREATE)) ? offset_q : period_q;

  ptrt_ms2tick #(
    .TICK_MS(TICK_MS)
  ) u_ms2tick (
    .ms_i   (div_in),
    .ticks_o(div_out)
  );

  assign count_wr = (op_q == ptrt_pkg::OP_CREATE) ? ptrt_pkg::COUNT_W'(q1_q)
                  : ptrt_pkg::COUNT_W'(pause_q) * ptrt_pkg::COUNT_W'(q1_q);

  always_comb begin
    ctl.create = (state_q == S_APPLY) && (op_q == ptrt_pkg::OP_CREATE);
    ctl.pause  = (state_q == S_APPLY) && (op_q == ptrt_pkg::OP_PAUSE);
    ctl.remove = (state_q == S_APPLY) && (op_q == ptrt_pkg::OP_DELETE);
    ctl.tick   = accept && (op_i == ptrt_pkg::OP_TICK);
    ctl.shift  = (state_q == S_SCAN);
  end

  for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
    logic due_next;
    if (g == TASK_SLOTS - 1) begin : g_tail
      assign due_next = 1'b0;
    end else begin : g_link
      assign due_next = due_w[g+1];
    end
    ptrt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .sel_i     (idx_q == SW'(g)),
      .period_i  (q2_q),
      .count_i   (count_wr),
      .due_next_i(due_next),
      .due_o     (due_w[g])
    );
  end

  assign any_due   = |due_w;
  assign rest_due  = |(due_w >> 1);
  assign step_wide = (SW + 3)'(step_q);

  always_comb begin
    state_d    = state_q;
    q1_d       = q1_q;
    q2_d       = q2_q;
    step_d     = step_q;
    strobe_d   = 1'b0;
    kind_d     = kind_q;
    status_d   = ptrt_pkg::STATUS_OK;
    due_task_d = '0;
    last_d     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (op_i == ptrt_pkg::OP_TICK) begin
            step_d  = '0;
            state_d = S_SCAN;
          end else if (!in_range) begin
            strobe_d = 1'b1;
            kind_d   = ptrt_pkg::KIND_ACK;
            status_d = ptrt_pkg::STATUS_REJECT;
            last_d   = 1'b1;
          end else if (op_i == ptrt_pkg::OP_DELETE) begin
            state_d = S_APPLY;
          end else begin
            state_d = S_DIV1;
          end
        end
      end
      S_DIV1: begin
        q1_d    = div_out;
        state_d = (op_q == ptrt_pkg::OP_CREATE) ? S_DIV2 : S_APPLY;
      end
      S_DIV2: begin
        q2_d    = div_out;
        state_d = S_APPLY;
      end
      S_APPLY: begin
        strobe_d = 1'b1;
        kind_d   = ptrt_pkg::KIND_ACK;
        last_d   = 1'b1;
        state_d  = S_IDLE;
      end
      S_SCAN: begin
        step_d = step_q + 1'b1;
        if ((step_q == '0) && !any_due) begin
          strobe_d = 1'b1;
          kind_d   = ptrt_pkg::KIND_IDLE;
          last_d   = 1'b1;
          state_d  = S_IDLE;
        end else if (due_w[0]) begin
          strobe_d   = 1'b1;
          kind_d     = ptrt_pkg::KIND_DUE;
          due_task_d = step_wide[2:0];
          last_d     = !rest_due;
          if (!rest_due) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_i;
      idx_q    <= task_index_i[SW-1:0];
      offset_q <= offset_ms_i;
      period_q <= period_ms_i;
      pause_q  <= pause_count_i;
    end
    q1_q       <= q1_d;
    q2_q       <= q2_d;
    step_q     <= step_d;
    kind_q     <= kind_d;
    status_q   <= status_d;
    due_task_q <= due_task_d;
    last_q     <= last_d;
  end

  assign busy_o     = (state_q != S_IDLE);
  assign strobe_o   = strobe_q;
  assign kind_o     = kind_q;
  assign status_o   = status_q;
  assign due_task_o = due_task_q;
  assign last_o     = last_q;

`ifndef SYNTHESIS
  // The final result of a request always coincides with the return to idle.
  a_last_ends_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o) |-> !busy_o)
    else $error("final result while the sequencer is still busy");

  a_more_results_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_o) |-> busy_o)
    else $error("non-final result while the sequencer is idle");

  // Every due flag must have left the chain once a tick is complete.
  a_chain_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> (due_w == '0))
    else $error("due flag left in the cell chain while idle");

  a_reject_only_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && (status_o == ptrt_pkg::STATUS_REJECT)) |-> (kind_o == ptrt_pkg::KIND_ACK))
    else $error("reject status on a tick result");
`endif

endmodule

@@ test/periodic_task_release_table_checker.sv @@
`timescale 1ns / 1ps

// Watches the request and result ports of the release table and keeps its own
// copy of the slot table. Every accepted request queues the results it should
// cause, and every strobed result is compared with the oldest one still queued.
module periodic_task_release_table_checker #(
  parameter int unsigned TASK_SLOTS = ptrt_pkg::TASK_SLOTS_DEF,
  parameter int unsigned TICK_MS    = ptrt_pkg::TICK_MS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  op_i,
  input  logic [5:0]  task_index_i,
  input  logic [15:0] offset_ms_i,
  input  logic [15:0] period_ms_i,
  input  logic [7:0]  pause_count_i,
  input  logic        strobe_i,
  input  logic [1:0]  kind_i,
  input  logic        status_i,
  input  logic [2:0]  due_task_i,
  input  logic        last_i,
  output int          mismatch_count_o,
  output int          pending_o
);

  localparam int unsigned SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  typedef struct packed {
    logic [1:0] kind;
    logic       status;
    logic [2:0] due_task;
    logic       last;
  } release_result_t;

  release_result_t                  expected_releases[$];
  logic                             slot_registered[TASK_SLOTS];
  logic [ptrt_pkg::MS_W-1:0]        slot_period_ms[TASK_SLOTS];
  logic [ptrt_pkg::COUNT_W-1:0]     slot_countdown[TASK_SLOTS];
  int                               mismatch_count = 0;

  assign mismatch_count_o = mismatch_count;

  function automatic logic [ptrt_pkg::COUNT_W-1:0] ms_to_ticks(
      input logic [ptrt_pkg::MS_W-1:0] ms);
    return ptrt_pkg::COUNT_W'(32'(ms) / TICK_MS);
  endfunction

  task automatic report_mismatch(input string message);
    $display("%0t: release table mismatch: %s", $realtime, message);
    mismatch_count++;
  endtask

  // Applies one accepted request to the slot table and queues its results.
  task automatic predict_release(input logic [1:0] op, input logic [5:0] index,
                                 input logic [ptrt_pkg::MS_W-1:0] offset_ms,
                                 input logic [ptrt_pkg::MS_W-1:0] period_ms,
                                 input logic [ptrt_pkg::PAUSE_W-1:0] pauses);
    logic              due_now[TASK_SLOTS];
    int                final_due;
    logic [31:0]       pause_ticks;
    logic [SLOT_W-1:0] slot;
    release_result_t   entry;
    final_due = -1;
    if (op == ptrt_pkg::OP_TICK) begin
      // Due slots are found and reloaded first, then every registered
      // countdown steps down and sticks at zero.
      for (int s = 0; s < TASK_SLOTS; s++) begin
        due_now[s] = 1'b0;
        if (slot_registered[s]) begin
          if (slot_countdown[s] == '0) begin
            slot_countdown[s] = ms_to_ticks(slot_period_ms[s]);
            due_now[s] = 1'b1;
            final_due = s;
          end
          if (slot_countdown[s] != '0) slot_countdown[s] = slot_countdown[s] - 1'b1;
        end
      end
      if (final_due < 0) begin
        entry = '{kind: ptrt_pkg::KIND_IDLE, status: ptrt_pkg::STATUS_OK, due_task: 3'd0,
                  last: 1'b1};
        expected_releases.push_back(entry);
      end else begin
        for (int s = 0; s < TASK_SLOTS; s++) begin
          if (due_now[s]) begin
            entry = '{kind: ptrt_pkg::KIND_DUE, status: ptrt_pkg::STATUS_OK,
                      due_task: 3'(s), last: (s == final_due)};
            expected_releases.push_back(entry);
          end
        end
      end
    end else if (index >= TASK_SLOTS) begin
      entry = '{kind: ptrt_pkg::KIND_ACK, status: ptrt_pkg::STATUS_REJECT, due_task: 3'd0,
                last: 1'b1};
      expected_releases.push_back(entry);
    end else begin
      slot = SLOT_W'(index);
      case (op)
        ptrt_pkg::OP_CREATE: begin
          slot_period_ms[slot]  = period_ms;
          slot_countdown[slot]  = ms_to_ticks(offset_ms);
          slot_registered[slot] = 1'b1;
        end
        ptrt_pkg::OP_PAUSE: begin
          if (slot_registered[slot]) begin
            pause_ticks = 32'(pauses) * 32'(ms_to_ticks(period_ms));
            slot_countdown[slot] = pause_ticks[ptrt_pkg::COUNT_W-1:0];
          end
        end
        default: begin
          slot_registered[slot] = 1'b0;
        end
      endcase
      entry = '{kind: ptrt_pkg::KIND_ACK, status: ptrt_pkg::STATUS_OK, due_task: 3'd0,
                last: 1'b1};
      expected_releases.push_back(entry);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_ports
    release_result_t awaited;
    if (!rst_ni) begin
      expected_releases.delete();
      for (int s = 0; s < TASK_SLOTS; s++) begin
        slot_registered[s] = 1'b0;
        slot_period_ms[s]  = '0;
        slot_countdown[s]  = '0;
      end
      pending_o <= 0;
    end else begin
      // Results are compared before a request on the same edge is predicted,
      // since that request cannot have caused them.
      if (strobe_i === 1'b1) begin
        if (expected_releases.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending (kind %0d, due_task %0d)",
                                    kind_i, due_task_i));
        end else begin
          awaited = expected_releases.pop_front();
          if (kind_i !== awaited.kind)
            report_mismatch($sformatf("kind expected %0d, got %0d", awaited.kind, kind_i));
          if (status_i !== awaited.status)
            report_mismatch($sformatf("status expected %0d, got %0d", awaited.status,
                                      status_i));
          if (due_task_i !== awaited.due_task)
            report_mismatch($sformatf("due_task expected %0d, got %0d", awaited.due_task,
                                      due_task_i));
          if (last_i !== awaited.last)
            report_mismatch($sformatf("last expected %0d, got %0d", awaited.last, last_i));
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0)
        predict_release(op_i, task_index_i, offset_ms_i, period_ms_i, pause_count_i);
      pending_o <= expected_releases.size();
    end
  end

endmodule

@@ test/periodic_task_release_table_unit_test.sv @@
`timescale 1ns / 1ps

module periodic_task_release_table_unit_test;

  localparam int unsigned SLOT_COUNT      = ptrt_pkg::TASK_SLOTS_DEF;
  localparam int unsigned RANDOM_REQUESTS = 350;
  localparam int unsigned CALM_TAIL       = 60;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        req_start;
  logic        busy;
  logic [1:0]  req_op;
  logic [5:0]  req_index;
  logic [15:0] req_offset_ms;
  logic [15:0] req_period_ms;
  logic [7:0]  req_pause_count;
  logic        res_strobe;
  logic [1:0]  res_kind;
  logic        res_status;
  logic [2:0]  res_due_task;
  logic        res_last;
  int          mismatch_count;
  int          pending_count;
  int unsigned cycle_count = 0;

  always #10 clk_i = ~clk_i;

  periodic_task_release_table_unit #(
    .TASK_SLOTS(SLOT_COUNT),
    .TICK_MS   (ptrt_pkg::TICK_MS_DEF)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (req_start),
    .busy_o       (busy),
    .op_i         (req_op),
    .task_index_i (req_index),
    .offset_ms_i  (req_offset_ms),
    .period_ms_i  (req_period_ms),
    .pause_count_i(req_pause_count),
    .strobe_o     (res_strobe),
    .kind_o       (res_kind),
    .status_o     (res_status),
    .due_task_o   (res_due_task),
    .last_o       (res_last)
  );

  periodic_task_release_table_checker #(
    .TASK_SLOTS(SLOT_COUNT),
    .TICK_MS   (ptrt_pkg::TICK_MS_DEF)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (req_start),
    .busy_i          (busy),
    .op_i            (req_op),
    .task_index_i    (req_index),
    .offset_ms_i     (req_offset_ms),
    .period_ms_i     (req_period_ms),
    .pause_count_i   (req_pause_count),
    .strobe_i        (res_strobe),
    .kind_i          (res_kind),
    .status_i        (res_status),
    .due_task_i      (res_due_task),
    .last_i          (res_last),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_count)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Returns at the edge that takes the request, with start still high.
  task automatic send_request(input logic [1:0] op, input logic [5:0] index,
                              input logic [15:0] offset_ms, input logic [15:0] period_ms,
                              input logic [7:0] pauses);
    req_start       <= 1'b1;
    req_op          <= op;
    req_index       <= index;
    req_offset_ms   <= offset_ms;
    req_period_ms   <= period_ms;
    req_pause_count <= pauses;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic hold_sender(input int unsigned cycles);
    req_start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // The pending count is registered, so it is read only from the next edge on.
  task automatic wait_for_drain();
    req_start <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  // Mostly short times so that slots come due often, now and then the full range.
  function automatic logic [15:0] pick_ms();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(0, 65535));
      1, 2:    return 16'($urandom_range(0, 40));
      default: return 16'($urandom_range(0, 6));
    endcase
  endfunction

  initial begin
    logic [1:0]  op;
    logic [5:0]  index;
    logic [7:0]  pauses;
    int unsigned pick;
    bit          idling;
    req_start       <= 1'b0;
    req_op          <= ptrt_pkg::OP_TICK;
    req_index       <= '0;
    req_offset_ms   <= '0;
    req_period_ms   <= '0;
    req_pause_count <= '0;
    rst_ni          <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Tick on an empty table, then a zero-period slot and rejected indexes.
    send_request(ptrt_pkg::OP_TICK,   6'd0,  16'd0, 16'd0, 8'd0);
    send_request(ptrt_pkg::OP_CREATE, 6'd0,  16'd0, 16'd0, 8'd0);
    send_request(ptrt_pkg::OP_CREATE, 6'd7,  16'd2, 16'd3, 8'd0);
    send_request(ptrt_pkg::OP_CREATE, 6'd63, 16'd1, 16'd1, 8'd1);
    send_request(ptrt_pkg::OP_CREATE, 6'd8,  16'd1, 16'd1, 8'd1);
    send_request(ptrt_pkg::OP_PAUSE,  6'd8,  16'd0, 16'd4, 8'd2);
    send_request(ptrt_pkg::OP_DELETE, 6'd63, 16'd0, 16'd0, 8'd0);
    repeat (4) send_request(ptrt_pkg::OP_TICK, 6'd0, 16'd0, 16'd0, 8'd0);
    // Pause and delete of an unregistered slot are still accepted.
    send_request(ptrt_pkg::OP_PAUSE,  6'd3,  16'd0, 16'd5, 8'd3);
    send_request(ptrt_pkg::OP_DELETE, 6'd5,  16'd0, 16'd0, 8'd0);
    send_request(ptrt_pkg::OP_CREATE, 6'd3,  16'hFFFF, 16'hFFFF, 8'd0);
    send_request(ptrt_pkg::OP_PAUSE,  6'd3,  16'd0, 16'hFFFF, 8'hFF);
    send_request(ptrt_pkg::OP_PAUSE,  6'd7,  16'd0, 16'd5, 8'd0);
    // Overwrite the rest so that every slot comes due on one tick.
    for (int s = 1; s < 7; s++)
      send_request(ptrt_pkg::OP_CREATE, 6'(s), 16'd0, 16'd0, 8'd0);
    send_request(ptrt_pkg::OP_TICK,   6'd0,  16'd0, 16'd0, 8'd0);
    send_request(ptrt_pkg::OP_DELETE, 6'd0,  16'd0, 16'd0, 8'd0);
    send_request(ptrt_pkg::OP_TICK,   6'd0,  16'd0, 16'd0, 8'd0);
    wait_for_drain();

    idling = 1'b1;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 40 == 0) idling = ($urandom_range(0, 2) != 0);
      if (n >= RANDOM_REQUESTS - CALM_TAIL) idling = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 45) op = ptrt_pkg::OP_TICK;
      else if (pick < 70) op = ptrt_pkg::OP_CREATE;
      else if (pick < 85) op = ptrt_pkg::OP_PAUSE;
      else op = ptrt_pkg::OP_DELETE;
      if ($urandom_range(0, 99) < 85) index = 6'($urandom_range(0, SLOT_COUNT - 1));
      else index = 6'($urandom_range(SLOT_COUNT, 63));
      if ($urandom_range(0, 7) == 0) pauses = 8'($urandom_range(0, 255));
      else pauses = 8'($urandom_range(0, 3));
      send_request(op, index, pick_ms(), pick_ms(), pauses);
      if (n % 120 == 60) wait_for_drain();
      else if (idling && $urandom_range(0, 3) == 0) hold_sender($urandom_range(1, 11));
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
